FILE: rtl/core/asc_pkg.sv
// asc_pkg: shared types and constants for the A/V sync sample-count correction block.
// No dependencies; every other file in rtl/core uses it.
`default_nettype none

package asc_pkg;

  // Payload and register widths
  localparam int unsigned DIFF_W    = 24;  // signed Q8.16 seconds
  localparam int unsigned NB_W      = 16;
  localparam int unsigned WANTED_W  = 17;
  localparam int unsigned RATE_W    = 18;
  localparam int unsigned THR_W     = 23;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned SUM_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RATE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_COEF       = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RST = 18'd44100;
  localparam logic [THR_W-1:0]  THR_RST  = 23'd761;
  localparam logic [COEF_W-1:0] COEF_RST = 16'd52057;

  // 10 s in Q.16: at or beyond this the filter restarts
  localparam logic signed [DIFF_W-1:0] NOSYNC_LIMIT = 24'sd655360;

  // Shared multiplier: 33-bit signed by 19-bit signed
  localparam int unsigned MUL_A_W = SUM_W + 1;
  localparam int unsigned MUL_B_W = RATE_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned TRUNC_W = PROD_W - 16;

  // Clamp bounds: nb*90/100 = floor(nb*9/10), nb*110/100 = floor(nb*11/10).
  // floor(x/10) = (x * 6710887) >> 26, exact for x below 1118481.
  localparam int unsigned PCT_MAX   = 10;
  localparam int unsigned LO_FACTOR = (100 - PCT_MAX) / 10;
  localparam int unsigned HI_FACTOR = (100 + PCT_MAX) / 10;
  localparam int unsigned SCALED_W  = 20;
  localparam int unsigned RECIP_W   = 23;
  localparam int unsigned RECIP_SH  = 26;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 23'd6710887;

  typedef enum logic [1:0] {
    MSEL_SUM,   // avg_coef * diff_sum
    MSEL_AVG,   // diff_sum * (1 - avg_coef)
    MSEL_COR    // av_diff * sample rate
  } mul_sel_e;

  typedef struct packed {
    logic     load;       // capture input word
    logic     clear;      // restart the filter
    logic     mul_en;     // register a product
    mul_sel_e mul_sel;
    logic     sum_upd;    // write the saturated running sum
    logic     cnt_inc;    // advance the measure count
    logic     bnd_lo;     // compute low clamp bound
    logic     bnd_hi;     // compute high clamp bound
    logic     res_nb;     // result is the frame's own count
    logic     res_clamp;  // result is the clamped corrected count
    logic     out_load;   // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic nosync; // |av_diff| at or above 10 s
    logic warm;   // still in the warm-up measures
    logic hit;    // average difference reached the threshold
  } status_t;

  // Q.16 product to integer, rounding toward zero
  function automatic logic signed [TRUNC_W-1:0] trunc16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    adj = p + (p[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    return $signed(adj[PROD_W-1:16]);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/asc_if.sv
// asc_in_if / asc_out_if: valid-ready channels for input frames and results.
// Depends on asc_pkg for payload widths.
`default_nettype none

interface asc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [asc_pkg::DIFF_W-1:0] av_diff;
  logic [asc_pkg::NB_W-1:0]          frame_len;

  modport source (output valid, output av_diff, output frame_len, input ready);
  modport sink   (input valid, input av_diff, input frame_len, output ready);
endinterface

interface asc_out_if;
  logic                           valid;
  logic                           ready;
  logic [asc_pkg::WANTED_W-1:0]   wanted_samples;

  modport source (output valid, output wanted_samples, input ready);
  modport sink   (input valid, input wanted_samples, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/audio_sync_sample_correction_top.sv
// audio_sync_sample_correction_top: A/V sync sample-count correction block.
// Instantiates asc_ctrl and asc_datapath; uses asc_pkg and the asc_if channels.
`default_nettype none

// Channel   Dir  Handshake      Word
// in_i      in   valid/ready    av_diff (s24 Q8.16 s), frame_len (u16)
// out_o     out  valid/ready    wanted_samples (u17)
// cfg       in   cfg_we_i       cfg_idx_i (0 rate, 1 threshold, 2 coef), cfg_data_i (u23)
//
// One frame is in flight at a time. A frame that runs the full correction path passes
// the range check, sum update, average, threshold test and clamp before its result loads
// into the output register: one shared 33x19 multiplier is used three times in sequence
// (sum decay, average, correction). Large differences and warm-up frames finish early.
// The next word is taken in the cycle its predecessor's result loads, so a stalled output
// holds one result while the following frame is computed; it then waits to load.
// Reset clears the running sum, the measure count and the output valid flag, and restores
// the register defaults (44100 Hz, threshold 761, coefficient 52057).
module audio_sync_sample_correction_top #(
  parameter int unsigned AVG_COUNT = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [asc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [asc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  asc_in_if.sink                          in_i,
  asc_out_if.source                       out_o
);
  import asc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence the frame; hold the result until the sink takes it
  asc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Filter state, arithmetic and output word
  asc_datapath #(
    .AVG_COUNT (AVG_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .av_diff_i        (in_i.av_diff),
    .frame_len_i      (in_i.frame_len),
    .cmd_i            (cmd),
    .status_o         (status),
    .wanted_samples_o (out_o.wanted_samples)
  );

endmodule

`default_nettype wire

FILE: rtl/core/asc_datapath.sv
// asc_datapath: configuration registers, filter state, shared multiplier, clamp and
// output register. Driven by asc_ctrl through asc_pkg::cmd_t; depends on asc_pkg.
`default_nettype none

module asc_datapath #(
  parameter int unsigned AVG_COUNT = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [asc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [asc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [asc_pkg::DIFF_W-1:0]  av_diff_i,
  input  logic [asc_pkg::NB_W-1:0]           frame_len_i,
  input  asc_pkg::cmd_t                      cmd_i,
  output asc_pkg::status_t                   status_o,
  output logic [asc_pkg::WANTED_W-1:0]       wanted_samples_o
);
  import asc_pkg::*;

  localparam int unsigned CNT_W = $clog2(AVG_COUNT + 1);
  localparam int unsigned ADD_W = TRUNC_W + 1;

  logic [RATE_W-1:0]  rate_q;
  logic [THR_W-1:0]   thr_q;
  logic [COEF_W-1:0]  coef_q;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q;

  logic signed [DIFF_W-1:0] diff_q;
  logic [NB_W-1:0]          nb_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [TRUNC_W-1:0] prod_t;

  logic [COEF_W:0]           one_minus;
  logic signed [ADD_W-1:0]   sum_raw;
  logic [TRUNC_W-1:0]        avg_mag;

  logic [SCALED_W-1:0]          scaled;
  logic [SCALED_W+RECIP_W-1:0]  recip;
  logic [WANTED_W-1:0]          bound;
  logic [WANTED_W-1:0]          lo_q, hi_q;

  logic signed [TRUNC_W-1:0] wanted_raw;
  logic signed [TRUNC_W-1:0] lo_s, hi_s;
  logic [WANTED_W-1:0]       clamped;
  logic [WANTED_W-1:0]       res_q;
  logic [WANTED_W-1:0]       wanted_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RST;
      thr_q  <= THR_RST;
      coef_q <= COEF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OUT_RATE:       rate_q <= cfg_data_i[RATE_W-1:0];
        REG_DIFF_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
        REG_AVG_COEF:       coef_q <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier operands
  assign one_minus = (COEF_W+1)'(1 << COEF_W) - {1'b0, coef_q};

  always_comb begin
    unique case (cmd_i.mul_sel)
      MSEL_SUM: begin
        mul_a = MUL_A_W'(sum_q);
        mul_b = $signed({{(MUL_B_W-COEF_W){1'b0}}, coef_q});
      end
      MSEL_AVG: begin
        mul_a = MUL_A_W'(sum_q);
        mul_b = $signed({{(MUL_B_W-COEF_W-1){1'b0}}, one_minus});
      end
      MSEL_COR: begin
        mul_a = MUL_A_W'(diff_q);
        mul_b = $signed({1'b0, rate_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_t = trunc16(prod_q);

  // Running sum: diff + coef*sum, saturated to 32 bits
  assign sum_raw = ADD_W'(diff_q) + ADD_W'(prod_t);

  always_comb begin
    if (sum_raw[ADD_W-1:SUM_W-1] == '0 || sum_raw[ADD_W-1:SUM_W-1] == '1) begin
      sum_d = sum_raw[SUM_W-1:0];
    end else if (sum_raw[ADD_W-1]) begin
      sum_d = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_d = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  assign avg_mag = prod_t[TRUNC_W-1] ? TRUNC_W'(-prod_t) : TRUNC_W'(prod_t);

  // Clamp bounds through one reciprocal multiply
  assign scaled = SCALED_W'(nb_q) * (cmd_i.bnd_hi ? SCALED_W'(HI_FACTOR)
                                                  : SCALED_W'(LO_FACTOR));
  assign recip  = (SCALED_W+RECIP_W)'(scaled) * (SCALED_W+RECIP_W)'(RECIP_MUL);
  assign bound  = recip[RECIP_SH +: WANTED_W];

  // Corrected count and clamp
  assign wanted_raw = $signed(TRUNC_W'(nb_q)) + prod_t;
  assign lo_s = $signed(TRUNC_W'(lo_q));
  assign hi_s = $signed(TRUNC_W'(hi_q));

  always_comb begin
    priority if (wanted_raw < lo_s) begin
      clamped = lo_q;
    end else if (wanted_raw > hi_s) begin
      clamped = hi_q;
    end else begin
      clamped = wanted_raw[WANTED_W-1:0];
    end
  end

  // Filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.sum_upd) sum_q <= sum_d;
      if (cmd_i.cnt_inc) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      diff_q <= av_diff_i;
      nb_q   <= frame_len_i;
    end
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.bnd_lo) lo_q <= bound;
    if (cmd_i.bnd_hi) hi_q <= bound;
    if (cmd_i.res_nb) begin
      res_q <= WANTED_W'(nb_q);
    end else if (cmd_i.res_clamp) begin
      res_q <= clamped;
    end
    if (cmd_i.out_load) wanted_q <= res_q;
  end

  assign status_o.nosync = (diff_q >= NOSYNC_LIMIT) || (diff_q <= -NOSYNC_LIMIT);
  assign status_o.warm   = cnt_q < CNT_W'(AVG_COUNT);
  assign status_o.hit    = avg_mag >= TRUNC_W'(thr_q);

  assign wanted_samples_o = wanted_q;

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |=> (cnt_q <= CNT_W'(AVG_COUNT)))
    else $error("measure count ran past its limit");

endmodule

`default_nettype wire

FILE: rtl/core/asc_ctrl.sv
// asc_ctrl: sequencer for one frame at a time and the output valid flag.
// Issues asc_pkg::cmd_t to asc_datapath and reads asc_pkg::status_t back.
`default_nettype none

module asc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  asc_pkg::status_t  status_i,
  output asc_pkg::cmd_t     cmd_o
);
  import asc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MSUM  = 3'd1;  // check range, coef*sum
  localparam logic [2:0] S_USUM  = 3'd2;  // saturate sum, low bound
  localparam logic [2:0] S_MAVG  = 3'd3;  // sum*(1-coef), high bound
  localparam logic [2:0] S_MCOR  = 3'd4;  // threshold test, diff*rate
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;  // wait for a free output slot

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.mul_sel = MSEL_SUM;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MSUM;
        end
      end
      S_MSUM: begin
        if (status_i.nosync) begin
          cmd_o.clear  = 1'b1;
          cmd_o.res_nb = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MSEL_SUM;
          state_d       = S_USUM;
        end
      end
      S_USUM: begin
        cmd_o.sum_upd = 1'b1;
        cmd_o.bnd_lo  = 1'b1;
        if (status_i.warm) begin
          cmd_o.cnt_inc = 1'b1;
          cmd_o.res_nb  = 1'b1;
          state_d       = S_DONE;
        end else begin
          state_d = S_MAVG;
        end
      end
      S_MAVG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MSEL_AVG;
        cmd_o.bnd_hi  = 1'b1;
        state_d       = S_MCOR;
      end
      S_MCOR: begin
        if (status_i.hit) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MSEL_COR;
          state_d       = S_CLAMP;
        end else begin
          cmd_o.res_nb = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_CLAMP: begin
        cmd_o.res_clamp = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          in_ready_o     = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_MSUM;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MSUM))
    else $error("accepted word did not start a frame");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_clear_on_nosync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> (status_i.nosync && state_q == S_MSUM))
    else $error("filter cleared without a large difference");

endmodule

`default_nettype wire
